/* sv/lrtrm_pkg.sv */
package lrtrm_pkg;

  localparam int unsigned MaxEntries = 32;
  localparam int unsigned CacheBytes = 16384;
  localparam int unsigned StoreBytes = 65536;

  localparam int unsigned IdW    = 5;
  localparam int unsigned CntW   = 6;
  localparam int unsigned SizeW  = 17;
  localparam int unsigned CoffW  = 15;
  localparam int unsigned StampW = 32;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_ACCESS = 2'd1,
    MODE_PIN    = 2'd2,
    MODE_UNPIN  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_ID  = 2'd1,
    ST_NO_ROOM = 2'd2,
    ST_NO_LOAD = 2'd3
  } status_t;

endpackage

/* sv/lru_tensor_residency_manager_top.sv */
// Residency manager for up to 32 entries with least-recently-used eviction and pinning.
// One request is taken at a time and one result beat is returned for each. Alloc, pin,
// unpin and any rejected request go straight to the result; an access first reads the
// entry's tables and, if it is not resident, checks whether it fits in the cache. Each
// eviction costs a full scan of the stamp RAM, one entry a cycle, since the stamp RAM
// has a single read port.
module lru_tensor_residency_manager_top
  import lrtrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_mode,
  input  logic [IdW-1:0]   in_entry_id,
  input  logic [SizeW-1:0] in_alloc_size,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [IdW-1:0]   out_result_id,
  output logic [CoffW-1:0] out_ram_offset,
  output logic [SizeW-1:0] out_store_offset,
  output logic [SizeW-1:0] out_entry_bytes,
  output logic             out_copy_needed,
  output logic [CntW-1:0]  out_evicted_count
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_FIT, S_SCAN, S_VIC, S_VSZ, S_OUT
  } state_t;

  state_t            state_r;
  logic [MaxEntries-1:0] resident_r, pinned_r;
  logic [CntW-1:0]   count_r, evicted_r, scan_idx_r;
  logic [StampW-1:0] stamp_r, best_stamp_r;
  logic [CoffW-1:0]  fill_r;
  logic [SizeW-1:0]  sfill_r, sz_r, so_r;
  logic [IdW-1:0]    id_r, best_r, cmp_idx_r;
  logic              found_r, cmp_vld_r;

  logic [1:0]        status_r;
  logic [IdW-1:0]    res_id_r;
  logic [CoffW-1:0]  ram_off_r;
  logic [SizeW-1:0]  store_off_r, bytes_r;
  logic              copy_r;

  logic              sz_we, so_we, co_we, st_we;
  logic [IdW-1:0]    sz_waddr, sz_raddr, co_waddr;
  logic [SizeW-1:0]  sz_wdata, sz_rdata, so_rdata;
  logic [CoffW-1:0]  co_rdata;
  logic [StampW-1:0] st_rdata;
  logic [SizeW:0]    store_sum, cache_sum;
  logic [SizeW:0]    round_sum;
  logic              accept, alloc_ok, id_ok, fits, elig;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign store_sum = {1'b0, sfill_r} + {1'b0, in_alloc_size};
  assign round_sum = {1'b0, in_alloc_size} + (SizeW+1)'(7);
  assign alloc_ok  = (count_r < CntW'(MaxEntries)) && (store_sum <= (SizeW+1)'(StoreBytes));
  assign id_ok     = {1'b0, in_entry_id} < count_r;
  assign cache_sum = (SizeW+1)'(fill_r) + {1'b0, sz_r};
  assign fits      = cache_sum <= (SizeW+1)'(CacheBytes);
  assign elig      = resident_r[cmp_idx_r] && !pinned_r[cmp_idx_r];

  always_comb begin
    sz_we    = 1'b0;
    so_we    = 1'b0;
    co_we    = 1'b0;
    st_we    = 1'b0;
    sz_waddr = count_r[IdW-1:0];
    sz_wdata = {round_sum[SizeW-1:3], 3'b000};
    co_waddr = id_r;
    sz_raddr = (state_r == S_IDLE) ? in_entry_id : best_r;
    if (accept && mode_t'(in_mode) == MODE_ALLOC && alloc_ok) begin
      sz_we = 1'b1;
      so_we = 1'b1;
    end
    if (accept && mode_t'(in_mode) == MODE_ACCESS && id_ok) begin
      st_we = 1'b1;
    end
    if (state_r == S_FIT && fits) begin
      co_we = 1'b1;
    end
  end

  lrtrm_ram #(.WIDTH(SizeW), .DEPTH(MaxEntries)) u_size_ram (
    .clk(clk), .we(sz_we), .waddr(sz_waddr), .wdata(sz_wdata),
    .raddr(sz_raddr), .rdata(sz_rdata)
  );

  lrtrm_ram #(.WIDTH(SizeW), .DEPTH(MaxEntries)) u_soff_ram (
    .clk(clk), .we(so_we), .waddr(sz_waddr), .wdata(sfill_r),
    .raddr(in_entry_id), .rdata(so_rdata)
  );

  lrtrm_ram #(.WIDTH(CoffW), .DEPTH(MaxEntries)) u_coff_ram (
    .clk(clk), .we(co_we), .waddr(co_waddr), .wdata(fill_r),
    .raddr(in_entry_id), .rdata(co_rdata)
  );

  lrtrm_ram #(.WIDTH(StampW), .DEPTH(MaxEntries)) u_stamp_ram (
    .clk(clk), .we(st_we), .waddr(in_entry_id), .wdata(stamp_r),
    .raddr(scan_idx_r[IdW-1:0]), .rdata(st_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      resident_r <= '0;
      pinned_r   <= '0;
      count_r    <= '0;
      stamp_r    <= '0;
      fill_r     <= '0;
      sfill_r    <= '0;
      evicted_r  <= '0;
      cmp_vld_r  <= 1'b0;
      found_r    <= 1'b0;
      scan_idx_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            id_r        <= in_entry_id;
            evicted_r   <= '0;
            status_r    <= ST_OK;
            res_id_r    <= '0;
            ram_off_r   <= '0;
            store_off_r <= '0;
            bytes_r     <= '0;
            copy_r      <= 1'b0;
            state_r     <= S_OUT;
            case (mode_t'(in_mode))
              MODE_ALLOC: begin
                if (count_r >= CntW'(MaxEntries)) begin
                  status_r <= ST_BAD_ID;
                end else if (!alloc_ok) begin
                  status_r <= ST_NO_ROOM;
                end else begin
                  res_id_r    <= count_r[IdW-1:0];
                  store_off_r <= sfill_r;
                  bytes_r     <= sz_wdata;
                  resident_r[count_r[IdW-1:0]] <= 1'b0;
                  pinned_r[count_r[IdW-1:0]]   <= 1'b0;
                  sfill_r <= store_sum[SizeW-1:0];
                  count_r <= count_r + 1'b1;
                end
              end
              MODE_ACCESS: begin
                if (!id_ok) begin
                  status_r <= ST_BAD_ID;
                end else begin
                  res_id_r <= in_entry_id;
                  stamp_r  <= stamp_r + 1'b1;
                  state_r  <= S_RD;
                end
              end
              default: begin
                if (!id_ok) begin
                  status_r <= ST_BAD_ID;
                end else begin
                  res_id_r <= in_entry_id;
                  pinned_r[in_entry_id] <= (mode_t'(in_mode) == MODE_PIN);
                end
              end
            endcase
          end
        end
        S_RD: begin
          sz_r <= sz_rdata;
          so_r <= so_rdata;
          if (resident_r[id_r]) begin
            ram_off_r   <= co_rdata;
            store_off_r <= so_rdata;
            bytes_r     <= sz_rdata;
            state_r     <= S_OUT;
          end else begin
            state_r <= S_FIT;
          end
        end
        S_FIT: begin
          if (fits) begin
            resident_r[id_r] <= 1'b1;
            fill_r      <= cache_sum[CoffW-1:0];
            ram_off_r   <= fill_r;
            store_off_r <= so_r;
            bytes_r     <= sz_r;
            copy_r      <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            scan_idx_r <= '0;
            cmp_vld_r  <= 1'b0;
            found_r    <= 1'b0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_idx_r < CntW'(MaxEntries)) begin
            scan_idx_r <= scan_idx_r + 1'b1;
            cmp_idx_r  <= scan_idx_r[IdW-1:0];
            cmp_vld_r  <= 1'b1;
          end else begin
            cmp_vld_r <= 1'b0;
            if (!cmp_vld_r) begin
              state_r <= S_VIC;
            end
          end
          if (cmp_vld_r && elig && (!found_r || st_rdata < best_stamp_r)) begin
            found_r      <= 1'b1;
            best_r       <= cmp_idx_r;
            best_stamp_r <= st_rdata;
          end
        end
        S_VIC: begin
          if (found_r) begin
            state_r <= S_VSZ;
          end else begin
            status_r <= ST_NO_LOAD;
            state_r  <= S_OUT;
          end
        end
        S_VSZ: begin
          resident_r[best_r] <= 1'b0;
          fill_r    <= fill_r - sz_rdata[CoffW-1:0];
          evicted_r <= evicted_r + 1'b1;
          state_r   <= S_FIT;
        end
        S_OUT: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = (state_r == S_OUT);
  assign out_status        = status_r;
  assign out_result_id     = res_id_r;
  assign out_ram_offset    = ram_off_r;
  assign out_store_offset  = store_off_r;
  assign out_entry_bytes   = bytes_r;
  assign out_copy_needed   = copy_r;
  assign out_evicted_count = evicted_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CoffW'(CacheBytes)) else $error("cache fill beyond capacity");
  a_evict_bound: assert property (@(posedge clk) disable iff (!rst_n)
    evicted_r <= count_r) else $error("more evictions than entries");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready) else $error("second item taken while busy");
  a_victim_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_VSZ |-> resident_r[best_r] && !pinned_r[best_r])
    else $error("victim not resident or pinned");
`endif

endmodule

/* sv/lrtrm_ram.sv */
module lrtrm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* bench/lru_tensor_residency_manager_top_test.sv */
module lru_tensor_residency_manager_top_test;
  import lrtrm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]       status;
    logic [IdW-1:0]   rid;
    logic [CoffW-1:0] roff;
    logic [SizeW-1:0] soff;
    logic [SizeW-1:0] bytes;
    logic             copy;
    logic [CntW-1:0]  evicted;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = '0;
  logic [IdW-1:0] in_entry_id = '0;
  logic [SizeW-1:0] in_alloc_size = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [IdW-1:0] out_result_id;
  logic [CoffW-1:0] out_ram_offset;
  logic [SizeW-1:0] out_store_offset;
  logic [SizeW-1:0] out_entry_bytes;
  logic out_copy_needed;
  logic [CntW-1:0] out_evicted_count;

  lru_tensor_residency_manager_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the residency table.
  logic [SizeW-1:0]  sh_size [MaxEntries];
  logic [SizeW-1:0]  sh_soff [MaxEntries];
  logic [CoffW-1:0]  sh_coff [MaxEntries];
  logic              sh_res [MaxEntries];
  logic              sh_pin [MaxEntries];
  logic [StampW-1:0] sh_stamp [MaxEntries];
  int unsigned sh_count, sh_cfill, sh_sfill;
  logic [StampW-1:0] sh_clock;

  outcome_t pending[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic outcome_t predict_residency(input mode_t m, input int unsigned id,
                                                 input int unsigned sz);
    outcome_t r;
    int victim;
    int unsigned need;
    r = '0;
    if (m == MODE_ALLOC) begin
      if (sh_count >= MaxEntries) r.status = ST_BAD_ID;
      else if (sh_sfill + sz > StoreBytes) r.status = ST_NO_ROOM;
      else begin
        sh_size[sh_count] = SizeW'((sz + 7) & ~32'd7);
        sh_soff[sh_count] = SizeW'(sh_sfill);
        sh_coff[sh_count] = '0;
        sh_res[sh_count] = 1'b0;
        sh_pin[sh_count] = 1'b0;
        sh_stamp[sh_count] = '0;
        sh_sfill += sz;
        r.status = ST_OK;
        r.rid = IdW'(sh_count);
        r.soff = sh_soff[sh_count];
        r.bytes = sh_size[sh_count];
        sh_count++;
      end
      return r;
    end
    if (id >= sh_count) begin
      r.status = ST_BAD_ID;
      return r;
    end
    r.rid = IdW'(id);
    if (m != MODE_ACCESS) begin
      sh_pin[id] = (m == MODE_PIN);
      return r;
    end
    sh_stamp[id] = sh_clock;
    sh_clock = sh_clock + 1;
    if (!sh_res[id]) begin
      need = sh_size[id];
      while (sh_cfill + need > CacheBytes) begin
        victim = -1;
        for (int i = 0; i < sh_count; i++)
          if (sh_res[i] && !sh_pin[i] && (victim < 0 || sh_stamp[i] < sh_stamp[victim]))
            victim = i;
        if (victim < 0) begin
          r.status = ST_NO_LOAD;
          return r;
        end
        sh_res[victim] = 1'b0;
        sh_cfill -= sh_size[victim];
        r.evicted++;
      end
      sh_coff[id] = CoffW'(sh_cfill);
      sh_res[id] = 1'b1;
      sh_cfill += need;
      r.copy = 1'b1;
    end
    r.roff = sh_coff[id];
    r.soff = sh_soff[id];
    r.bytes = sh_size[id];
    return r;
  endfunction

  task automatic send_request(input mode_t m, input int unsigned id, input int unsigned sz);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 31) @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= m;
    in_entry_id <= IdW'(id);
    in_alloc_size <= SizeW'(sz);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending.push_back(predict_residency(m, id, sz));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    outcome_t got, want;
    cycles++;
    if (cycles > 20000000) begin
      $display("Verification failed");
      $finish;
    end
    if (out_valid && out_ready) begin
      got = {out_status, out_result_id, out_ram_offset, out_store_offset, out_entry_bytes,
             out_copy_needed, out_evicted_count};
      if (pending.size() == 0) report("result beat with nothing expected");
      else begin
        want = pending.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d want %0d", got.status, want.status));
        if (got.rid !== want.rid)
          report($sformatf("result_id %0d want %0d", got.rid, want.rid));
        if (got.roff !== want.roff)
          report($sformatf("ram_offset %0d want %0d", got.roff, want.roff));
        if (got.soff !== want.soff)
          report($sformatf("store_offset %0d want %0d", got.soff, want.soff));
        if (got.bytes !== want.bytes)
          report($sformatf("entry_bytes %0d want %0d", got.bytes, want.bytes));
        if (got.copy !== want.copy)
          report($sformatf("copy_needed %0d want %0d", got.copy, want.copy));
        if (got.evicted !== want.evicted)
          report($sformatf("evicted_count %0d want %0d", got.evicted, want.evicted));
      end
    end
  end

  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 31);

  task automatic test_directed;
    send_request(MODE_ACCESS, 0, 0);
    send_request(MODE_PIN, 31, 0);
    send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_ALLOC, 0, 65537);
    send_request(MODE_ALLOC, 0, 16385);
    send_request(MODE_ALLOC, 0, 8000);
    send_request(MODE_ALLOC, 0, 1);
    send_request(MODE_ACCESS, 0, 0);
    send_request(MODE_PIN, 2, 0);
    send_request(MODE_ACCESS, 2, 0);
    send_request(MODE_ACCESS, 3, 0);
    send_request(MODE_ACCESS, 1, 0);
    send_request(MODE_ACCESS, 3, 0);
    send_request(MODE_ACCESS, 3, 0);
    send_request(MODE_UNPIN, 2, 0);
    send_request(MODE_ACCESS, 1, 0);
    send_request(MODE_ALLOC, 0, 131071);
    drain();
  endtask

  task automatic test_random;
    mode_t m;
    int unsigned sz;
    for (int n = 0; n < 1050; n++) begin
      if (n == 500) begin
        drain();
        calm = 1'b1;
      end
      if (n == 650) calm = 1'b0;
      m = mode_t'($urandom_range(9) < 2 ? MODE_ALLOC : $urandom_range(3));
      case ($urandom_range(9))
        0: sz = $urandom_range(131071);
        1: sz = $urandom_range(16384, 8000);
        default: sz = $urandom_range(4000);
      endcase
      send_request(m, (sh_count > 0 && $urandom_range(9) != 0) ?
                   $urandom_range(sh_count - 1) : $urandom_range(31), sz);
    end
    drain();
  endtask

  // Small entries fill whatever is left of the table, so that the full-table case is met.
  task automatic test_fill_table;
    for (int n = 0; n < 40; n++) send_request(MODE_ALLOC, 0, $urandom_range(15));
    send_request(MODE_ACCESS, 31, 0);
    drain();
  endtask

  initial begin
    for (int i = 0; i < MaxEntries; i++) begin
      sh_res[i] = 1'b0;
      sh_pin[i] = 1'b0;
      sh_stamp[i] = '0;
    end
    sh_count = 0;
    sh_cfill = 0;
    sh_sfill = 0;
    sh_clock = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    test_fill_table();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

/* files.f */
sv/lrtrm_pkg.sv
sv/lrtrm_ram.sv
sv/lru_tensor_residency_manager_top.sv
bench/lru_tensor_residency_manager_top_test.sv
